// ===== rtl/fifo_with_overwrite_and_compare_defines.svh =====
// Assertion macros used by the queue RTL.
`ifndef FIFO_WITH_OVERWRITE_AND_COMPARE_DEFINES_SVH
`define FIFO_WITH_OVERWRITE_AND_COMPARE_DEFINES_SVH

`ifndef SYNTH
`define FWOC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("queue check failed");
`define FWOC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("queue check failed");
`else
`define FWOC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define FWOC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/fwoc_pkg.sv =====
// Types and constants for the overwrite/compare queue.
`timescale 1ns / 1ps
package fwoc_pkg;

   // ring depth; index and fill widths below are sized for it
   localparam int DEPTH    = 16;
   localparam int TYPE_W   = 2;
   localparam int IDX_W    = 4;
   localparam int FILL_W   = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 5;

   typedef enum logic [TYPE_W-1:0] {
      REQ_PUSH = 2'd0,
      REQ_POP  = 2'd1,
      REQ_CMP  = 2'd2
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_QUEUE_LIMIT = 2'd0,
      CSR_OVERWRITE   = 2'd1
   } csr_index_type;

   localparam logic [FILL_W-1:0] LIMIT_RESET = 5'd16;

endpackage

// ===== rtl/fifo_with_overwrite_and_compare.sv =====
// Ring-buffer queue with fill limit, overwrite of oldest entry and head compare.
// Throughput: one request per cycle unless the response stalls; pointers and count
// update at accept, the one RAM read port (registered) returns data for pop/compare.
// Reset: pointers, count and valids clear, match flag sets, limit 16, no
// overwrite; entry storage is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`include "fifo_with_overwrite_and_compare_defines.svh"
module fifo_with_overwrite_and_compare
   import fwoc_pkg::*;
#(
   parameter int ITEM_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [TYPE_W-1:0]     req_type,
   input  logic [ITEM_BITS-1:0]  req_item_value,
   input  logic [IDX_W-1:0]      req_cmp_index,
   input  logic                  req_cmp_last,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_accepted,
   output logic [ITEM_BITS-1:0]  rsp_pop_data,
   output logic [FILL_W-1:0]     rsp_fill_level,
   output logic                  rsp_is_full,
   output logic                  rsp_is_empty,
   output logic                  rsp_seq_match,
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int SUM_W = ((PTR_W > FILL_W) ? PTR_W : FILL_W) + 1;
   localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);

   // p + n modulo DEPTH, valid for n <= DEPTH
   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                  input logic [FILL_W-1:0] n);
      logic [SUM_W-1:0] s;
      s = SUM_W'(p) + SUM_W'(n);
      if (s >= DEPTH_S) begin
         s = s - DEPTH_S;
      end
      return s[PTR_W-1:0];
   endfunction

   // configuration
   logic [FILL_W-1:0] limit_ff;
   logic              overwrite_ff;

   // queue state
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [FILL_W-1:0] count_ff, count_in;
   logic              match_ff, match_in;

   // stage 1: request waiting on RAM read data
   logic                 s1_valid_ff, s1_valid_in;
   req_kind_type         s1_kind_ff;
   logic [ITEM_BITS-1:0] s1_item_ff;
   logic                 s1_idx_zero_ff;
   logic                 s1_last_ff;
   logic                 s1_in_range_ff;
   logic                 s1_ok_ff;
   logic [FILL_W-1:0]    s1_fill_ff;
   logic                 s1_full_ff;
   logic                 s1_empty_ff;

   // stage 2: response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_acc_ff, rsp_acc_in;
   logic [ITEM_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [FILL_W-1:0]    rsp_fill_ff;
   logic                 rsp_full_ff;
   logic                 rsp_empty_ff;
   logic                 rsp_seq_ff, rsp_seq_in;

   logic                 req_acc;
   logic                 s1_adv;
   logic [FILL_W-1:0]    lim;
   logic [FILL_W-1:0]    drop;
   logic                 in_range;
   logic                 op_ok;
   logic                 ram_wr;
   logic                 ram_rd;
   logic [PTR_W-1:0]     ram_raddr;
   logic [ITEM_BITS-1:0] ram_rdata;
   logic                 cmp_base;
   logic                 cmp_hit;

   // ---------------------------------------------------------------- control
   assign csr_ready    = 1'b1;
   assign s1_adv       = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall    = s1_valid_ff & ~s1_adv;
   assign req_acc      = req_valid & ~req_stall;
   assign s1_valid_in  = req_acc | (s1_valid_ff & ~s1_adv);
   assign rsp_valid_in = s1_adv | (rsp_valid_ff & rsp_stall);

   // effective limit: 0 acts as 1, clamp at DEPTH
   always_comb begin
      if (limit_ff == '0) begin
         lim = FILL_W'(1);
      end else if (SUM_W'(limit_ff) > DEPTH_S) begin
         lim = FILL_W'(DEPTH);
      end else begin
         lim = limit_ff;
      end
   end

   assign drop     = count_ff - lim + FILL_W'(1);
   assign in_range = FILL_W'(req_cmp_index) < count_ff;

   // ------------------------------------------------------- accept-side update
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      ram_wr    = 1'b0;
      ram_rd    = 1'b0;
      ram_raddr = head_ff;
      op_ok     = 1'b0;
      if (req_acc) begin
         case (req_kind_type'(req_type))
            REQ_PUSH: begin
               if (count_ff < lim) begin
                  ram_wr   = 1'b1;
                  tail_in  = wrap_add(tail_ff, FILL_W'(1));
                  count_in = count_ff + FILL_W'(1);
                  op_ok    = 1'b1;
               end else if (overwrite_ff) begin
                  // drop enough oldest entries to leave limit-1, then append
                  ram_wr   = 1'b1;
                  head_in  = wrap_add(head_ff, drop);
                  tail_in  = wrap_add(tail_ff, FILL_W'(1));
                  count_in = lim;
                  op_ok    = 1'b1;
               end
            end
            REQ_POP: begin
               if (count_ff != '0) begin
                  ram_rd   = 1'b1;
                  head_in  = wrap_add(head_ff, FILL_W'(1));
                  count_in = count_ff - FILL_W'(1);
                  op_ok    = 1'b1;
               end
            end
            REQ_CMP: begin
               ram_rd = 1'b1;
               if (in_range) begin
                  ram_raddr = wrap_add(head_ff, FILL_W'(req_cmp_index));
               end
            end
            default: begin
            end
         endcase
      end
   end

   fwoc_ram #(
      .WIDTH (ITEM_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (tail_ff),
      .wr_data (req_item_value),
      .rd_en   (ram_rd),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ------------------------------------------------------ response formation
   assign cmp_base = s1_idx_zero_ff | match_ff;
   assign cmp_hit  = cmp_base & s1_in_range_ff & (ram_rdata == s1_item_ff);

   always_comb begin
      rsp_acc_in  = 1'b0;
      rsp_data_in = '0;
      rsp_seq_in  = match_ff;
      match_in    = match_ff;
      case (s1_kind_ff)
         REQ_PUSH: begin
            rsp_acc_in = s1_ok_ff;
         end
         REQ_POP: begin
            rsp_acc_in = s1_ok_ff;
            if (s1_ok_ff) begin
               rsp_data_in = ram_rdata;
            end
         end
         REQ_CMP: begin
            rsp_acc_in = cmp_hit;
            rsp_seq_in = cmp_hit;
            // end of sequence re-arms the running flag
            match_in   = s1_last_ff | cmp_hit;
         end
         default: begin
         end
      endcase
   end

   // -------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         overwrite_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         match_ff     <= 1'b1;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_QUEUE_LIMIT: limit_ff     <= csr_wdata;
               CSR_OVERWRITE:   overwrite_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            match_ff <= match_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_kind_ff     <= req_kind_type'(req_type);
         s1_item_ff     <= req_item_value;
         s1_idx_zero_ff <= (req_cmp_index == '0);
         s1_last_ff     <= req_cmp_last;
         s1_in_range_ff <= in_range;
         s1_ok_ff       <= op_ok;
         s1_fill_ff     <= count_in;
         s1_full_ff     <= (count_in >= lim);
         s1_empty_ff    <= (count_in == '0);
      end
      if (s1_adv) begin
         rsp_acc_ff   <= rsp_acc_in;
         rsp_data_ff  <= rsp_data_in;
         rsp_fill_ff  <= s1_fill_ff;
         rsp_full_ff  <= s1_full_ff;
         rsp_empty_ff <= s1_empty_ff;
         rsp_seq_ff   <= rsp_seq_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = rsp_acc_ff;
   assign rsp_pop_data   = rsp_data_ff;
   assign rsp_fill_level = rsp_fill_ff;
   assign rsp_is_full    = rsp_full_ff;
   assign rsp_is_empty   = rsp_empty_ff;
   assign rsp_seq_match  = rsp_seq_ff;

   // -------------------------------------------------------------- checks
   `FWOC_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, SUM_W'(count_ff) <= DEPTH_S)
   `FWOC_ASSERT_IMPLIES(a_ring_consistent, clock, reset, 1'b1, wrap_add(head_ff, count_ff) == tail_ff)
   `FWOC_ASSERT_IMPLIES(a_no_rsp_overrun, clock, reset, rsp_valid_ff && rsp_stall, !s1_adv)
   `FWOC_ASSERT_NEXT(a_pop_decrements, clock, reset, req_acc && (req_type == REQ_POP) && (count_ff != '0), count_ff == FILL_W'($past(count_ff) - FILL_W'(1)))

endmodule

// ===== rtl/fwoc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module fwoc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== verif/fifo_with_overwrite_and_compare_tb.sv =====
// Self-checking testbench for the overwrite/compare queue: directed table, then random phases.
`timescale 1ns / 1ps
module fifo_with_overwrite_and_compare_tb;
   import fwoc_pkg::*;

   localparam int ITEM_BITS   = 8;
   localparam int IDLE_LIMIT  = 400;
   localparam int PHASES      = 14;
   localparam int PHASE_ITEMS = 75;

   localparam logic [TYPE_W-1:0]    REQ_NOP      = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   localparam logic [CSR_DATA_W-1:0] PHASE_LIMIT [PHASES] =
      '{5'd16, 5'd3, 5'd1, 5'd0, 5'd31, 5'd2, 5'd16, 5'd8, 5'd1, 5'd5, 5'd16, 5'd12,
        5'd4, 5'd16};
   localparam logic PHASE_OVERWRITE [PHASES] =
      '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
        1'b1, 1'b0};

   typedef struct packed {
      logic                 accepted;
      logic [ITEM_BITS-1:0] pop_data;
      logic [FILL_W-1:0]    fill_level;
      logic                 is_full;
      logic                 is_empty;
      logic                 seq_match;
   } queue_status_type;

   typedef struct packed {
      logic [TYPE_W-1:0]    kind;
      logic [ITEM_BITS-1:0] value;
      logic [IDX_W-1:0]     index;
      logic                 last;
      logic                 pinned;
      queue_status_type     want;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [TYPE_W-1:0]     req_type;
   logic [ITEM_BITS-1:0]  req_item_value;
   logic [IDX_W-1:0]      req_cmp_index;
   logic                  req_cmp_last;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_accepted;
   logic [ITEM_BITS-1:0]  rsp_pop_data;
   logic [FILL_W-1:0]     rsp_fill_level;
   logic                  rsp_is_full;
   logic                  rsp_is_empty;
   logic                  rsp_seq_match;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   fifo_with_overwrite_and_compare #(
      .ITEM_BITS (ITEM_BITS)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_item_value (req_item_value),
      .req_cmp_index  (req_cmp_index),
      .req_cmp_last   (req_cmp_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_accepted   (rsp_accepted),
      .rsp_pop_data   (rsp_pop_data),
      .rsp_fill_level (rsp_fill_level),
      .rsp_is_full    (rsp_is_full),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_seq_match  (rsp_seq_match),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // shadow copy of the queue and its registers
   logic [ITEM_BITS-1:0]  shadow_store [DEPTH];
   logic [IDX_W-1:0]      shadow_head;
   logic [IDX_W-1:0]      shadow_tail;
   logic [FILL_W-1:0]     shadow_count;
   logic                  shadow_match;
   logic [CSR_DATA_W-1:0] limit_reg;
   logic                  overwrite_reg;

   queue_status_type expected_status [$];
   stim_row_type     directed_rows [$];
   stim_row_type     current_row;
   int               error_count;
   bit               quiet_phase;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic queue_status_type predict_status(input logic [TYPE_W-1:0] kind,
         input logic [ITEM_BITS-1:0] value, input logic [IDX_W-1:0] index,
         input logic last);
      queue_status_type st;
      int               limit_eff;
      int               drop;
      logic             hit;
      st = '0;
      if (limit_reg == 0)
         limit_eff = 1;
      else if (int'(limit_reg) > DEPTH)
         limit_eff = DEPTH;
      else
         limit_eff = int'(limit_reg);
      st.seq_match = shadow_match;
      case (kind)
         REQ_PUSH: begin
            if (int'(shadow_count) < limit_eff || overwrite_reg) begin
               // limit may sit below the count: drop enough to leave limit-1
               if (int'(shadow_count) >= limit_eff) begin
                  drop = int'(shadow_count) - limit_eff + 1;
                  shadow_head  = IDX_W'((int'(shadow_head) + drop) % DEPTH);
                  shadow_count = FILL_W'(int'(shadow_count) - drop);
               end
               shadow_store[shadow_tail] = value;
               shadow_tail  = IDX_W'((int'(shadow_tail) + 1) % DEPTH);
               shadow_count = shadow_count + 1'b1;
               st.accepted  = 1'b1;
            end
         end
         REQ_POP: begin
            if (shadow_count != 0) begin
               st.pop_data  = shadow_store[shadow_head];
               shadow_head  = IDX_W'((int'(shadow_head) + 1) % DEPTH);
               shadow_count = shadow_count - 1'b1;
               st.accepted  = 1'b1;
            end
         end
         REQ_CMP: begin
            if (index == 0)
               shadow_match = 1'b1;
            hit = 1'b0;
            if (int'(index) < int'(shadow_count))
               hit = (shadow_store[IDX_W'((int'(shadow_head) + int'(index)) % DEPTH)] == value);
            if (!hit)
               shadow_match = 1'b0;
            st.seq_match = shadow_match;
            st.accepted  = shadow_match;
            if (last)
               shadow_match = 1'b1;
         end
         default: ;
      endcase
      st.fill_level = shadow_count;
      st.is_full    = (int'(shadow_count) >= limit_eff);
      st.is_empty   = (shadow_count == 0);
      return st;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic check_field(input string what, input int got, input int want);
      if (got != want)
         report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin
      queue_status_type st;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_QUEUE_LIMIT: limit_reg = csr_wdata;
               CSR_OVERWRITE:   overwrite_reg = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_status.size() == 0) begin
               report_mismatch("response with no request pending", 1, 0);
            end else begin
               st = expected_status.pop_front();
               check_field("accepted", rsp_accepted, st.accepted);
               check_field("pop_data", rsp_pop_data, st.pop_data);
               check_field("fill_level", rsp_fill_level, st.fill_level);
               check_field("is_full", rsp_is_full, st.is_full);
               check_field("is_empty", rsp_is_empty, st.is_empty);
               check_field("seq_match", rsp_seq_match, st.seq_match);
            end
         end
         if (req_valid && !req_stall) begin
            st = predict_status(req_type, req_item_value, req_cmp_index, req_cmp_last);
            if (current_row.pinned)
               st = current_row.want;
            expected_status.push_back(st);
         end
      end
   end

   // response side back-pressure, drawn per response
   initial begin
      int hold;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         hold = quiet_phase ? 0 : $urandom_range(0, 11);
         if (hold > 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall = 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // entered and left at a falling edge
   task automatic send_request(input stim_row_type row);
      int gap;
      gap = quiet_phase ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      current_row    = row;
      req_type       = row.kind;
      req_item_value = row.value;
      req_cmp_index  = row.index;
      req_cmp_last   = row.last;
      req_valid      = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
         input logic [CSR_DATA_W-1:0] data);
      csr_index = idx;
      csr_wdata = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic settle_queue();
      while (expected_status.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      stim_row_type row;
      int           sent;
      int           push_pct;
      int           pick;
      int           seq_len;
      int           miss_at;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = REQ_PUSH;
      req_item_value = '0;
      req_cmp_index  = '0;
      req_cmp_last   = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = CSR_QUEUE_LIMIT;
      csr_wdata      = '0;
      current_row    = '0;
      error_count    = 0;
      quiet_phase    = 1'b0;
      foreach (shadow_store[i])
         shadow_store[i] = '0;
      shadow_head   = '0;
      shadow_tail   = '0;
      shadow_count  = '0;
      shadow_match  = 1'b1;
      limit_reg     = LIMIT_RESET;
      overwrite_reg = 1'b0;

      // kind, value, index, last, pinned, {acc, data, fill, full, empty, seq}
      directed_rows.push_back('{REQ_POP, 8'h00, 4'd0, 1'b0, 1'b1,
                                '{1'b0, 8'h00, 5'd0, 1'b0, 1'b1, 1'b1}});
      directed_rows.push_back('{REQ_NOP, 8'hFF, 4'hF, 1'b1, 1'b1,
                                '{1'b0, 8'h00, 5'd0, 1'b0, 1'b1, 1'b1}});
      directed_rows.push_back('{REQ_CMP, 8'h00, 4'd0, 1'b1, 1'b1,
                                '{1'b0, 8'h00, 5'd0, 1'b0, 1'b1, 1'b0}});
      directed_rows.push_back('{REQ_CMP, 8'hFF, 4'hF, 1'b0, 1'b1,
                                '{1'b0, 8'h00, 5'd0, 1'b0, 1'b1, 1'b0}});
      // match flag left low by the open sequence shows up on pushes
      directed_rows.push_back('{REQ_PUSH, 8'h00, 4'd0, 1'b0, 1'b0, '0});
      directed_rows.push_back('{REQ_PUSH, 8'hFF, 4'hF, 1'b1, 1'b0, '0});
      directed_rows.push_back('{REQ_PUSH, 8'hA5, 4'd3, 1'b0, 1'b0, '0});
      directed_rows.push_back('{REQ_CMP, 8'h00, 4'd0, 1'b0, 1'b0, '0});
      directed_rows.push_back('{REQ_CMP, 8'hFF, 4'd1, 1'b0, 1'b0, '0});
      directed_rows.push_back('{REQ_CMP, 8'hA5, 4'd2, 1'b1, 1'b0, '0});
      directed_rows.push_back('{REQ_CMP, 8'h00, 4'd0, 1'b0, 1'b0, '0});
      directed_rows.push_back('{REQ_CMP, 8'h5A, 4'd1, 1'b1, 1'b0, '0});
      // sequence running past the fill level
      directed_rows.push_back('{REQ_CMP, 8'h00, 4'd0, 1'b0, 1'b0, '0});
      directed_rows.push_back('{REQ_CMP, 8'h00, 4'd3, 1'b1, 1'b0, '0});
      directed_rows.push_back('{REQ_CMP, 8'hFF, 4'd0, 1'b1, 1'b0, '0});
      directed_rows.push_back('{REQ_POP, 8'h3C, 4'd0, 1'b0, 1'b0, '0});
      directed_rows.push_back('{REQ_POP, 8'h00, 4'd0, 1'b0, 1'b0, '0});
      directed_rows.push_back('{REQ_POP, 8'h00, 4'd0, 1'b0, 1'b0, '0});
      directed_rows.push_back('{REQ_POP, 8'h00, 4'd0, 1'b0, 1'b1,
                                '{1'b0, 8'h00, 5'd0, 1'b0, 1'b1, 1'b1}});
      directed_rows.push_back('{REQ_PUSH, 8'hFF, 4'd0, 1'b0, 1'b0, '0});
      directed_rows.push_back('{REQ_CMP, 8'hFF, 4'd0, 1'b1, 1'b0, '0});
      directed_rows.push_back('{REQ_NOP, 8'h00, 4'd0, 1'b0, 1'b0, '0});
      directed_rows.push_back('{REQ_POP, 8'h00, 4'd0, 1'b0, 1'b1,
                                '{1'b1, 8'hFF, 5'd0, 1'b0, 1'b1, 1'b1}});

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i]);
      req_valid = 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         settle_queue();
         write_register(CSR_QUEUE_LIMIT, PHASE_LIMIT[p]);
         write_register(CSR_OVERWRITE, {{(CSR_DATA_W-1){1'b0}}, PHASE_OVERWRITE[p]});
         if (p == 4) begin
            // unmapped indexes are ignored
            write_register(CSR_SPARE_LO, 5'h1F);
            write_register(CSR_SPARE_HI, 5'h0A);
         end
         csr_valid   = 1'b0;
         quiet_phase = (p % 4 == 2);
         push_pct    = (p == 0) ? 85 : $urandom_range(30, 80);
         sent        = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            row  = '0;
            if (pick < 60) begin
               row.kind  = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
               row.value = ITEM_BITS'($urandom_range(0, 255));
               row.index = IDX_W'($urandom_range(0, 15));
               row.last  = 1'($urandom_range(0, 1));
               send_request(row);
               sent++;
            end else if (pick < 88) begin
               // well-formed sequence from the head, sometimes past the end or with a miss
               seq_len = (shadow_count == 0) ? 1 : $urandom_range(1, int'(shadow_count));
               if ($urandom_range(0, 4) == 0 && seq_len < DEPTH)
                  seq_len++;
               miss_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, seq_len - 1) : -1;
               for (int k = 0; k < seq_len; k++) begin
                  row       = '0;
                  row.kind  = REQ_CMP;
                  row.index = IDX_W'(k);
                  row.last  = (k == seq_len - 1);
                  if (k < int'(shadow_count))
                     row.value = shadow_store[IDX_W'((int'(shadow_head) + k) % DEPTH)];
                  else
                     row.value = ITEM_BITS'($urandom_range(0, 255));
                  if (k == miss_at)
                     row.value = row.value ^ ITEM_BITS'($urandom_range(1, 255));
                  send_request(row);
                  sent++;
               end
            end else begin
               row.value = ITEM_BITS'($urandom_range(0, 255));
               row.index = IDX_W'($urandom_range(0, 15));
               row.last  = 1'($urandom_range(0, 1));
               if ($urandom_range(0, 2) == 0) begin
                  row.kind = REQ_NOP;
                  send_request(row);
               end else begin
                  row.kind = REQ_CMP;
                  send_request(row);
                  sent++;
               end
            end
         end
         req_valid = 1'b0;
      end

      settle_queue();
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
